### hw/rtl/abvs_pkg.sv
package abvs_pkg;

    localparam int DEF_STEP_WIDTH    = 32;
    localparam int DEF_FRACTION_BITS = 16;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    localparam logic [1:0] ORD_0     = 2'd0;
    localparam logic [1:0] ORD_1     = 2'd1;
    localparam logic [1:0] ORD_2     = 2'd2;
    localparam logic [1:0] ORD_3     = 2'd3;
    localparam logic [1:0] ORD_RESET = ORD_3;

    typedef struct packed {
        logic [1:0] ord;
        logic       div0;
    } t_class;

endpackage

### hw/rtl/abvs_front.sv
module abvs_front
    import abvs_pkg::*;
#(
    parameter int STEP_WIDTH = DEF_STEP_WIDTH
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_cfg_we,
    input  logic [1:0]                                i_cfg_wdata,
    input  logic                                      i_s_tvalid,
    output logic                                      o_s_tready,
    input  logic [((3*STEP_WIDTH+7)/8)*8-1:0]         i_s_tdata,
    output logic                                      o_q_push,
    output logic [3*STEP_WIDTH+2:0]                   o_q_data,
    input  logic                                      i_q_full
);

    localparam int W = STEP_WIDTH;

    logic [1:0]   r_order;
    logic [W-1:0] w_h0, w_h1, w_h2;
    t_class       w_cls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= ORD_RESET;
        end else if (i_cfg_we) begin
            r_order <= i_cfg_wdata;
        end
    end

    assign w_h0 = i_s_tdata[W-1:0];
    assign w_h1 = i_s_tdata[2*W-1:W];
    assign w_h2 = i_s_tdata[3*W-1:2*W];

    // order zero runs as order one
    always_comb begin
        w_cls.ord  = (r_order == ORD_0) ? ORD_1 : r_order;
        unique case (w_cls.ord)
            ORD_3:   w_cls.div0 = (w_h1 == '0) || (w_h2 == '0);
            ORD_2:   w_cls.div0 = (w_h1 == '0);
            default: w_cls.div0 = 1'b0;
        endcase
    end

    assign o_s_tready = !i_q_full;
    assign o_q_push   = i_s_tvalid && !i_q_full;
    assign o_q_data   = {w_cls, w_h2, w_h1, w_h0};

endmodule

### hw/rtl/abvs_queue.sv
module abvs_queue
    import abvs_pkg::*;
#(
    parameter int WIDTH = 3*DEF_STEP_WIDTH+3,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### hw/rtl/abvs_back.sv
module abvs_back
    import abvs_pkg::*;
#(
    parameter int STEP_WIDTH    = DEF_STEP_WIDTH,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_q_valid,
    input  logic [3*STEP_WIDTH+2:0]              i_q_data,
    output logic                                 o_q_pop,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [((3*STEP_WIDTH+7)/8)*8-1:0]    o_m_tdata,
    output logic [1:0]                           o_m_tuser
);

    localparam int W     = STEP_WIDTH;
    localparam int F     = FRACTION_BITS;
    localparam int ODW   = ((3*W+7)/8)*8;
    localparam int BW    = W+4;
    localparam int PW    = 2*W+4;
    localparam int DW    = 2*W+4;
    localparam int NW    = 2*W+5;
    localparam int QB    = W+2;
    localparam int NNW   = NW+F+1;
    localparam int HW    = NNW-QB;
    localparam int CMPW  = (HW > DW) ? HW : DW;
    localparam int CNTW  = $clog2(QB+1);

    localparam logic [W+1:0] LIM_NEG = {3'b001, {(W-1){1'b0}}};
    localparam logic [W+1:0] LIM_POS = LIM_NEG - 1'b1;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_MUL_D, S_SCALE, S_MUL_N, S_ADD,
        S_DIV_INIT, S_DIV, S_STORE, S_OUT
    } t_state;

    t_state          r_state;
    logic [W-1:0]    r_h0, r_h1, r_h2;
    logic [1:0]      r_ord;
    logic            r_div0;
    logic [1:0]      r_k;
    logic [W-1:0]    r_m;
    logic [BW-1:0]   r_b;
    logic [PW-1:0]   r_acc;
    logic [CNTW-1:0] r_cnt;
    logic [DW-1:0]   r_den;
    logic [NW-1:0]   r_num;
    logic [DW-1:0]   r_rem;
    logic [QB-1:0]   r_lo;
    logic [QB-1:0]   r_q;
    logic            r_big;
    logic [W-1:0]    r_w [3];
    logic            r_sat;
    logic            r_out_valid;
    logic [ODW-1:0]  r_out_data;
    logic [1:0]      r_out_user;

    logic [W:0]      w_s;
    logic [BW-1:0]   w_h0x2, w_h1x3, w_h2x3;
    logic [W-1:0]    w_da, w_na;
    logic [W:0]      w_db;
    logic [BW-1:0]   w_nb;
    logic            w_k6, w_addden, w_neg;
    logic [1:0]      w_last;
    logic [W+4:0]    w_sum;
    logic [PW-1:0]   w_acc_step;
    logic [DW-1:0]   w_den_scaled;
    logic [NNW-1:0]  w_nn;
    logic [HW-1:0]   w_hi;
    logic            w_big;
    logic [DW:0]     w_r2;
    logic            w_ge;
    logic [W+1:0]    w_mag, w_lim, w_magc;
    logic            w_sat_now;
    logic [W-1:0]    w_wt;

    // operand selection for the current weight
    always_comb begin
        w_s    = {1'b0, r_h1} + {1'b0, r_h2};
        w_h0x2 = BW'({r_h0, 1'b0});
        w_h1x3 = BW'({r_h1, 1'b0}) + BW'(r_h1);
        w_h2x3 = BW'({r_h2, 1'b0}) + BW'(r_h2);
        w_da    = W'(1);
        w_db    = (W+1)'(1);
        w_k6    = 1'b0;
        w_na    = '0;
        w_nb    = '0;
        w_addden = 1'b1;
        w_neg   = 1'b0;
        w_last  = 2'd0;
        unique case (r_ord)
            ORD_3: begin
                w_last = 2'd2;
                w_k6   = 1'b1;
                w_na   = r_h0;
                unique case (r_k)
                    2'd0: begin
                        w_da = r_h1;
                        w_db = w_s;
                        w_nb = w_h0x2 + (w_h1x3 << 1) + w_h2x3;
                    end
                    2'd1: begin
                        w_da     = r_h1;
                        w_db     = {1'b0, r_h2};
                        w_nb     = w_h0x2 + w_h1x3 + w_h2x3;
                        w_addden = 1'b0;
                        w_neg    = 1'b1;
                    end
                    default: begin
                        w_da     = r_h2;
                        w_db     = w_s;
                        w_nb     = w_h0x2 + w_h1x3;
                        w_addden = 1'b0;
                    end
                endcase
            end
            ORD_2: begin
                w_last = 2'd1;
                w_da   = r_h1;
                w_db   = (W+1)'(2);
                w_na   = r_h0;
                w_nb   = BW'(1);
                if (r_k != 2'd0) begin
                    w_addden = 1'b0;
                    w_neg    = 1'b1;
                end
            end
            default: begin
                w_last = 2'd0;
            end
        endcase
    end

    // shift-add multiplier step, divider step, rounding and saturation
    always_comb begin
        w_sum        = {1'b0, r_acc[PW-1:W]} + (r_m[0] ? {1'b0, r_b} : '0);
        w_acc_step   = {w_sum, r_acc[W-1:1]};
        w_den_scaled = w_k6 ? ((r_acc << 2) + (r_acc << 1)) : r_acc;
        w_nn         = {r_num, {(F+1){1'b0}}};
        w_hi         = w_nn[NNW-1:QB];
        w_big        = CMPW'(w_hi) >= CMPW'(r_den);
        w_r2         = {r_rem, r_lo[QB-1]};
        w_ge         = w_r2 >= {1'b0, r_den};
        w_mag        = (r_q >> 1) + (W+2)'(r_q[0]);
        w_lim        = w_neg ? LIM_NEG : LIM_POS;
        w_sat_now    = r_big || (w_mag > w_lim);
        w_magc       = w_sat_now ? w_lim : w_mag;
        w_wt         = w_neg ? (~w_magc[W-1:0] + 1'b1) : w_magc[W-1:0];
    end

    assign o_q_pop    = (r_state == S_IDLE) && i_q_valid;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_tready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_h0   <= i_q_data[W-1:0];
                        r_h1   <= i_q_data[2*W-1:W];
                        r_h2   <= i_q_data[3*W-1:2*W];
                        r_ord  <= i_q_data[3*W+2:3*W+1];
                        r_div0 <= i_q_data[3*W];
                        r_k    <= 2'd0;
                        r_sat  <= 1'b0;
                        r_w[0] <= '0;
                        r_w[1] <= '0;
                        r_w[2] <= '0;
                        r_state <= i_q_data[3*W] ? S_OUT : S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_m     <= w_da;
                    r_b     <= BW'(w_db);
                    r_acc   <= '0;
                    r_cnt   <= CNTW'(W);
                    r_state <= S_MUL_D;
                end
                S_MUL_D: begin
                    r_acc <= w_acc_step;
                    r_m   <= r_m >> 1;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CNTW'(1)) begin
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    r_den   <= w_den_scaled;
                    r_m     <= w_na;
                    r_b     <= w_nb;
                    r_acc   <= '0;
                    r_cnt   <= CNTW'(W);
                    r_state <= S_MUL_N;
                end
                S_MUL_N: begin
                    r_acc <= w_acc_step;
                    r_m   <= r_m >> 1;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CNTW'(1)) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_num   <= NW'(r_acc) + (w_addden ? NW'(r_den) : '0);
                    r_state <= S_DIV_INIT;
                end
                S_DIV_INIT: begin
                    r_big   <= w_big;
                    r_rem   <= DW'(w_hi);
                    r_lo    <= w_nn[QB-1:0];
                    r_q     <= '0;
                    r_cnt   <= CNTW'(QB);
                    r_state <= w_big ? S_STORE : S_DIV;
                end
                S_DIV: begin
                    r_rem <= w_ge ? DW'(w_r2 - {1'b0, r_den}) : DW'(w_r2);
                    r_lo  <= r_lo << 1;
                    r_q   <= {r_q[QB-2:0], w_ge};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CNTW'(1)) begin
                        r_state <= S_STORE;
                    end
                end
                S_STORE: begin
                    r_w[r_k] <= w_wt;
                    r_sat    <= r_sat || w_sat_now;
                    if (r_k == w_last) begin
                        r_state <= S_OUT;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_LOAD;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= ODW'({r_w[2], r_w[1], r_w[0]});
                        r_out_user  <= r_div0 ? ST_DIV0 : (r_sat ? ST_SAT : ST_OK);
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### hw/rtl/adams_bashforth_variable_step_coeffs_core.sv
// Variable-step Adams-Bashforth weights of order 1 to 3 from three past step sizes (newest
// first, unsigned Q with FRACTION_BITS fraction bits), given as signed fixed-point weights
// rounded to nearest with ties away from zero and saturated. Status on o_m_tuser: 0 ok,
// 1 zero step as divisor (all weights zero), 2 some weight saturated. The order register is
// sampled when a step set enters, a zero is run as order one. Items enter a two-entry queue
// and can be taken every cycle while it has room; the back end takes one item at a time and
// needs, per weight, two serial shift-add products and a bit-serial restoring division, then
// hands the weights to the output register; a weight whose quotient is far out of range skips
// its division, and a zero-divisor item goes straight to the output.
module adams_bashforth_variable_step_coeffs_core
    import abvs_pkg::*;
#(
    parameter int STEP_WIDTH    = DEF_STEP_WIDTH,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [1:0]                        i_cfg_wdata,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // dt_newest, dt_previous, dt_oldest
    input  logic [((3*STEP_WIDTH+7)/8)*8-1:0] i_s_tdata,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // weight_newest, weight_previous, weight_oldest
    output logic [((3*STEP_WIDTH+7)/8)*8-1:0] o_m_tdata,
    // status
    output logic [1:0]                        o_m_tuser
);

    localparam int QW = 3*STEP_WIDTH+3;

    logic          w_push, w_pop, w_full, w_empty;
    logic [QW-1:0] w_q_in, w_q_out;

    abvs_front #(
        .STEP_WIDTH (STEP_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_q_push    (w_push),
        .o_q_data    (w_q_in),
        .i_q_full    (w_full)
    );

    abvs_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_q_in),
        .i_pop   (w_pop),
        .o_data  (w_q_out),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    abvs_back #(
        .STEP_WIDTH    (STEP_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (!w_empty),
        .i_q_data   (w_q_out),
        .o_q_pop    (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

`ifndef SYNTHESIS
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser == ST_OK || o_m_tuser == ST_DIV0 || o_m_tuser == ST_SAT))
        else $error("invalid status code");

    a_div0_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == ST_DIV0) |-> (o_m_tdata[3*STEP_WIDTH-1:0] == '0))
        else $error("zero divisor result carries nonzero weights");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("back end took an item from an empty queue");
`endif

endmodule
